[rtl/tne_pkg.sv]
// Shared types and constants for the tile neighbourhood enumerator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tne_pkg;

   // Field widths fixed by the interface
   localparam int IDX_W      = 16;   // tile index
   localparam int SIDE_REG_W = 9;    // map_columns / map_rows registers
   localparam int EXT_W      = 2;    // x_extent / y_extent
   localparam int CNT_W      = 3;    // run position, vertical step (up to 7)
   localparam int TOT_W      = 6;    // results per transaction (up to 49)
   localparam int CMP_W      = 17;   // divider compare width
   localparam int AREA_W     = 2 * SIDE_REG_W;

   // Extent saturation limit
   localparam int MAX_EXTENT = 3;

   // Default for the largest grid side
   localparam int MAX_SIDE_DEFAULT = 256;

   // Reset value of both grid size registers
   localparam logic [SIDE_REG_W-1:0] MAP_SIDE_RESET = 9'd16;

   // Depth of the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_COLUMNS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_ROWS    = 1'd1;

   // One request as taken from the input channel
   typedef struct packed {
      logic [IDX_W-1:0] center_index;
      logic [EXT_W-1:0] x_extent;
      logic [EXT_W-1:0] y_extent;
      logic             include_center;
   } item_type;

   // Classified request handed from front to back
   typedef struct packed {
      logic [IDX_W-1:0] center;
      logic [EXT_W-1:0] n_right;
      logic [EXT_W-1:0] n_left;
      logic [EXT_W-1:0] n_above;
      logic [EXT_W-1:0] n_below;
      logic             keep_center;
      logic             none;
      logic [TOT_W-1:0] total;
   } job_type;

   typedef enum logic [2:0] {
      FRONT_IDLE,
      FRONT_CHECK,
      FRONT_DIVIDE,
      FRONT_COUNT,
      FRONT_TOTAL,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_RUN,
      BACK_VERT,
      BACK_EMPTY
   } back_state_type;

endpackage

`default_nettype wire

[rtl/tne_front.sv]
// Front end: takes requests, locates the center in the grid with a
// bit-serial divider and works out the neighbour counts. Uses tne_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tne_front import tne_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire item_type              req_item,
   input  wire logic [SIDE_REG_W-1:0] cols,
   input  wire logic [SIDE_REG_W-1:0] rows,
   output logic                       push_valid,
   input  wire logic                  push_full,
   output job_type                    push_job
);

   localparam int SIDE_W = $clog2(MAX_SIDE);
   localparam int STEP_W = (SIDE_W > 1) ? $clog2(SIDE_W) : 1;
   localparam logic [EXT_W-1:0] EXT_LIMIT = EXT_W'(MAX_EXTENT);

   front_state_type state_ff, state_in;

   logic               buf_valid_ff;
   item_type           buf_item_ff;
   logic [AREA_W-1:0]  area_ff;

   logic [IDX_W-1:0]   center_ff;
   logic [EXT_W-1:0]   xe_ff, ye_ff;
   logic               keep_ff;
   logic               none_ff;
   logic [IDX_W-1:0]   rem_ff;
   logic [SIDE_W-1:0]  quo_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [EXT_W-1:0]   nr_ff, nl_ff, na_ff, nb_ff;
   logic [TOT_W-1:0]   total_ff;

   logic               take;
   logic               req_accept;
   logic               in_grid;
   logic [CMP_W-1:0]   shifted;
   logic [CMP_W-1:0]   rem_wide;
   logic               ge;
   logic [SIDE_REG_W-1:0] col, row, right_room, below_room;
   logic [CNT_W-1:0]   run_cnt, vert_cnt;
   logic [TOT_W-1:0]   area_cnt;

   // Input buffer accepts a new transaction while the previous one is worked on
   assign take       = (state_ff == FRONT_IDLE) && buf_valid_ff;
   assign req_stall  = buf_valid_ff && !take;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else if (req_accept) begin
         buf_valid_ff <= 1'b1;
      end else if (take) begin
         buf_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         buf_item_ff <= req_item;
      end
   end

   // Grid area, tracked every cycle from the size registers
   always_ff @(posedge clock) begin
      area_ff <= AREA_W'(cols) * AREA_W'(rows);
   end

   assign in_grid = AREA_W'(center_ff) < area_ff;

   // One quotient bit per cycle
   assign shifted  = CMP_W'(cols) << step_ff;
   assign rem_wide = CMP_W'(rem_ff);
   assign ge       = rem_wide >= shifted;

   // Neighbour room on each side of the center
   assign col        = SIDE_REG_W'(rem_ff);
   assign row        = SIDE_REG_W'(quo_ff);
   assign right_room = cols - SIDE_REG_W'(1) - col;
   assign below_room = rows - SIDE_REG_W'(1) - row;

   assign run_cnt  = CNT_W'(1) + CNT_W'(nr_ff) + CNT_W'(nl_ff);
   assign vert_cnt = CNT_W'(na_ff) + CNT_W'(nb_ff);
   assign area_cnt = TOT_W'(run_cnt) * TOT_W'(vert_cnt);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and outputs
   always_comb begin
      state_in   = state_ff;
      push_valid = 1'b0;
      case (state_ff)
         FRONT_IDLE: begin
            if (buf_valid_ff) begin
               state_in = FRONT_CHECK;
            end
         end
         FRONT_CHECK: begin
            state_in = in_grid ? FRONT_DIVIDE : FRONT_PUSH;
         end
         FRONT_DIVIDE: begin
            if (step_ff == '0) begin
               state_in = FRONT_COUNT;
            end
         end
         FRONT_COUNT: begin
            state_in = FRONT_TOTAL;
         end
         FRONT_TOTAL: begin
            state_in = FRONT_PUSH;
         end
         FRONT_PUSH: begin
            push_valid = 1'b1;
            if (!push_full) begin
               state_in = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   // Working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         FRONT_IDLE: begin
            if (buf_valid_ff) begin
               center_ff <= buf_item_ff.center_index;
               xe_ff     <= (buf_item_ff.x_extent > EXT_LIMIT) ? EXT_LIMIT
                                                               : buf_item_ff.x_extent;
               ye_ff     <= (buf_item_ff.y_extent > EXT_LIMIT) ? EXT_LIMIT
                                                               : buf_item_ff.y_extent;
               keep_ff   <= buf_item_ff.include_center;
            end
         end
         FRONT_CHECK: begin
            none_ff <= !in_grid;
            rem_ff  <= center_ff;
            quo_ff  <= '0;
            step_ff <= STEP_W'(SIDE_W - 1);
         end
         FRONT_DIVIDE: begin
            if (ge) begin
               rem_ff <= IDX_W'(rem_wide - shifted);
            end
            quo_ff  <= (quo_ff << 1) | SIDE_W'(ge);
            step_ff <= step_ff - STEP_W'(1);
         end
         FRONT_COUNT: begin
            nr_ff <= (right_room < SIDE_REG_W'(xe_ff)) ? EXT_W'(right_room) : xe_ff;
            nl_ff <= (col < SIDE_REG_W'(xe_ff)) ? EXT_W'(col) : xe_ff;
            na_ff <= (row < SIDE_REG_W'(ye_ff)) ? EXT_W'(row) : ye_ff;
            nb_ff <= (below_room < SIDE_REG_W'(ye_ff)) ? EXT_W'(below_room) : ye_ff;
         end
         FRONT_TOTAL: begin
            total_ff <= area_cnt + TOT_W'(keep_ff) + TOT_W'(nr_ff) + TOT_W'(nl_ff);
            none_ff  <= (area_cnt == '0) && !keep_ff && (nr_ff == '0) && (nl_ff == '0);
         end
         default: begin
            none_ff <= none_ff;
         end
      endcase
   end

   always_comb begin
      push_job.center      = center_ff;
      push_job.n_right     = nr_ff;
      push_job.n_left      = nl_ff;
      push_job.n_above     = na_ff;
      push_job.n_below     = nb_ff;
      push_job.keep_center = keep_ff;
      push_job.none        = none_ff;
      push_job.total       = total_ff;
   end

endmodule

`default_nettype wire

[rtl/tne_queue.sv]
// Short queue of classified transactions between front and back.
// Uses job_type and QUEUE_DEPTH from tne_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tne_queue import tne_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_full,
   input  wire job_type push_job,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output job_type      pop_job
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               do_push, do_pop;

   assign push_full = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_valid && pop_ready;
   assign pop_job   = slot_ff[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + COUNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/tne_back.sv]
// Back end: walks the row run and the vertical neighbours of each run tile,
// one tile per cycle unless stalled, into the output register. Uses tne_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tne_back import tne_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [SIDE_REG_W-1:0] cols,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire job_type               pop_job,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [IDX_W-1:0]           rsp_tile_index,
   output logic                       rsp_no_tile,
   output logic                       rsp_last
);

   back_state_type state_ff, state_in;

   job_type          job_ff;
   logic [CNT_W-1:0] j_ff, v_ff;
   logic [IDX_W-1:0] rt_ff, tile_ff;
   logic [TOT_W-1:0] rem_ff;

   logic             rsp_valid_ff;
   logic [IDX_W-1:0] rsp_tile_index_ff;
   logic             rsp_no_tile_ff;
   logic             rsp_last_ff;

   logic             out_free;
   logic             advance;
   logic             c_emit;
   logic [IDX_W-1:0] c_tile;
   logic             c_none;
   logic             c_last;

   logic [IDX_W-1:0] col_step;
   logic [CNT_W-1:0] run_end, vert_end, n_right, n_above;
   logic             run_done, vert_done;
   logic [IDX_W-1:0] run_next_tile, rt_next;

   assign col_step  = IDX_W'(cols);
   assign n_right   = CNT_W'(job_ff.n_right);
   assign n_above   = CNT_W'(job_ff.n_above);
   assign run_end   = CNT_W'(job_ff.n_right) + CNT_W'(job_ff.n_left);
   assign vert_end  = CNT_W'(job_ff.n_above) + CNT_W'(job_ff.n_below) - CNT_W'(1);
   assign run_done  = (j_ff == run_end);
   assign vert_done = (v_ff == vert_end);

   // Next tile of the run: right of center, then jump to center-1, then leftward
   assign run_next_tile = (j_ff < n_right)  ? tile_ff + IDX_W'(1) :
                          (j_ff == n_right) ? job_ff.center - IDX_W'(1) :
                                              tile_ff - IDX_W'(1);
   assign rt_next       = (j_ff < n_right)  ? rt_ff + IDX_W'(1) :
                          (j_ff == n_right) ? job_ff.center - IDX_W'(1) :
                                              rt_ff - IDX_W'(1);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and current candidate result
   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      advance   = 1'b0;
      c_emit    = 1'b0;
      c_tile    = tile_ff;
      c_none    = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               state_in = pop_job.none ? BACK_EMPTY : BACK_RUN;
            end
         end
         BACK_RUN: begin
            advance = out_free;
            c_emit  = (j_ff != '0) || job_ff.keep_center;
            if (out_free && run_done) begin
               state_in = (vert_end == {CNT_W{1'b1}}) ? BACK_IDLE : BACK_VERT;
            end
         end
         BACK_VERT: begin
            advance = out_free;
            c_emit  = 1'b1;
            if (out_free && vert_done && run_done) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_EMPTY: begin
            advance = out_free;
            c_emit  = 1'b1;
            c_tile  = '0;
            c_none  = 1'b1;
            if (out_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   assign c_last = (rem_ff == TOT_W'(1));

   // Walk registers; j_ff is reused as the run position in the vertical phase
   always_ff @(posedge clock) begin
      case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) begin
               job_ff  <= pop_job;
               j_ff    <= '0;
               tile_ff <= pop_job.center;
               rem_ff  <= pop_job.none ? TOT_W'(1) : pop_job.total;
            end
         end
         BACK_RUN: begin
            if (advance) begin
               if (c_emit) begin
                  rem_ff <= rem_ff - TOT_W'(1);
               end
               if (run_done) begin
                  j_ff    <= '0;
                  v_ff    <= '0;
                  rt_ff   <= job_ff.center;
                  tile_ff <= (n_above != '0) ? job_ff.center - col_step
                                             : job_ff.center + col_step;
               end else begin
                  j_ff    <= j_ff + CNT_W'(1);
                  tile_ff <= run_next_tile;
               end
            end
         end
         BACK_VERT: begin
            if (advance) begin
               rem_ff <= rem_ff - TOT_W'(1);
               if (vert_done) begin
                  j_ff    <= j_ff + CNT_W'(1);
                  v_ff    <= '0;
                  rt_ff   <= rt_next;
                  tile_ff <= (n_above != '0) ? rt_next - col_step : rt_next + col_step;
               end else begin
                  v_ff <= v_ff + CNT_W'(1);
                  if (v_ff + CNT_W'(1) == n_above) begin
                     tile_ff <= rt_ff + col_step;
                  end else if (v_ff + CNT_W'(1) < n_above) begin
                     tile_ff <= tile_ff - col_step;
                  end else begin
                     tile_ff <= tile_ff + col_step;
                  end
               end
            end
         end
         BACK_EMPTY: begin
            if (advance) begin
               rem_ff <= rem_ff - TOT_W'(1);
            end
         end
         default: begin
            rem_ff <= rem_ff;
         end
      endcase
   end

   // Output register: load whenever it is empty or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && c_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && advance && c_emit) begin
         rsp_tile_index_ff <= c_tile;
         rsp_no_tile_ff    <= c_none;
         rsp_last_ff       <= c_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tile_index = rsp_tile_index_ff;
   assign rsp_no_tile    = rsp_no_tile_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/tile_neighbourhood_enumerator.sv]
// Tile neighbourhood enumerator. For each request (center tile, extents,
// include-center flag) the block lists the row run around the center and then
// the tiles above and below each run tile, one result per cycle while the
// result side does not stall, with last set on the final one; an out-of-grid
// center or an empty area gives one no_tile result. A front end locates the
// center with a bit-serial divider, one quotient bit per cycle, and waits on a
// full queue. Its input buffer takes the next request while one is in
// progress. A two-entry queue feeds the back end. The back end loads a request
// and then steps through the run positions and the vertical positions, and
// holds while the result side stalls. The back end sets the sustained rate for
// large areas, the front end for small areas and off-grid centers.
// map_columns and map_rows must be written only while the block is idle;
// values of 0 act as 1 and values above MAX_SIDE as MAX_SIDE.
// Depends on tne_pkg, tne_front, tne_queue and tne_back.
`timescale 1ns / 1ps
`default_nettype none

module tile_neighbourhood_enumerator import tne_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [IDX_W-1:0]       req_center_index,
   input  wire logic [EXT_W-1:0]       req_x_extent,
   input  wire logic [EXT_W-1:0]       req_y_extent,
   input  wire logic                   req_include_center,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [IDX_W-1:0]            rsp_tile_index,
   output logic                        rsp_no_tile,
   output logic                        rsp_last,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [SIDE_REG_W-1:0]  csr_data
);

   localparam logic [SIDE_REG_W-1:0] SIDE_LIMIT = SIDE_REG_W'(MAX_SIDE);

   logic [SIDE_REG_W-1:0] map_columns_ff, map_rows_ff;
   logic [SIDE_REG_W-1:0] cols, rows;
   item_type              req_item;
   logic                  push_valid, push_full;
   job_type               push_job;
   logic                  pop_valid, pop_ready;
   job_type               pop_job;

   // Grid size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_columns_ff <= MAP_SIDE_RESET;
         map_rows_ff    <= MAP_SIDE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAP_COLUMNS: map_columns_ff <= csr_data;
            CSR_MAP_ROWS:    map_rows_ff    <= csr_data;
            default:         map_rows_ff    <= map_rows_ff;
         endcase
      end
   end

   // Clamp grid sides into 1..MAX_SIDE
   assign cols = (map_columns_ff == '0)       ? SIDE_REG_W'(1) :
                 (map_columns_ff > SIDE_LIMIT) ? SIDE_LIMIT : map_columns_ff;
   assign rows = (map_rows_ff == '0)          ? SIDE_REG_W'(1) :
                 (map_rows_ff > SIDE_LIMIT)    ? SIDE_LIMIT : map_rows_ff;

   always_comb begin
      req_item.center_index   = req_center_index;
      req_item.x_extent       = req_x_extent;
      req_item.y_extent       = req_y_extent;
      req_item.include_center = req_include_center;
   end

   tne_front #(
      .MAX_SIDE(MAX_SIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .cols       (cols),
      .rows       (rows),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_job   (push_job)
   );

   tne_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   tne_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cols           (cols),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_job        (pop_job),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tile_index (rsp_tile_index),
      .rsp_no_tile    (rsp_no_tile),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
